// ===== hdl/cspu_pkg.sv =====
// Shared types and constants for the CAN signal pack/unpack block.
package cspu_pkg;

    localparam int FRAME_BYTES_DEF = 64;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_INSERT  = 2'd2;
    localparam logic [1:0] MODE_EXTRACT = 2'd3;

    localparam int         CFG_ADDR_W            = 3;
    localparam logic       REG_IDX_PAYLOAD_BYTES = 1'b0;
    localparam logic [6:0] PAYLOAD_BYTES_RESET   = 7'd8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
        logic [8:0]  start_bit;
        logic [6:0]  bit_count;
        logic        motorola_order;
        logic        sign_extend;
        logic [63:0] signal_value;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_value;
        logic        range_error;
    } t_out_item;

    // Sequencer to datapath control
    typedef struct packed {
        logic       load;
        logic       step;
        logic       err;
        logic       zero_res;
        logic       sext;
        logic [2:0] sh;
        logic [6:0] nbits;
    } t_dp_ctl;

endpackage

// ===== hdl/cspu_store.sv =====
// Payload byte store: one write port, one registered read port.
module cspu_store #(
    parameter int FRAME_BYTES = cspu_pkg::FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import cspu_pkg::*;

    logic [7:0] r_mem [FRAME_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cspu_ctrl.sv =====
// Item sequencer: range check, byte span, and the byte-by-byte address walk.
module cspu_ctrl #(
    parameter int FRAME_BYTES = cspu_pkg::FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cspu_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    input  logic [6:0]          i_payload_bytes,
    input  logic                i_res_ready,
    output logic                o_res_valid,
    output cspu_pkg::t_dp_ctl   o_ctl,
    output logic [63:0]         o_value,
    output logic                o_re,
    output logic [AW-1:0]       o_raddr,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr
);
    import cspu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]    r_state;
    t_in_item      r_item;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_waddr;
    logic [3:0]    r_left;
    logic          r_inc;
    logic          r_write;
    logic          r_rv;

    logic [6:0]    len;
    logic [2:0]    s;
    logic [5:0]    sb;
    logic [7:0]    span;
    logic [4:0]    kb;
    logic [6:0]    last;
    logic          is_ins;
    logic          sig_mode;
    logic          bad_count;
    logic          c_err;
    logic          c_inc;
    logic          c_write;
    logic [AW-1:0] c_addr;
    logic [3:0]    c_k;
    logic [2:0]    c_sh;
    logic [6:0]    c_nbits;
    logic          c_sext;
    logic [63:0]   c_value;
    logic          issue;

    // Decode the held item: first/last byte touched, alignment and direction
    always_comb begin
        len = (i_payload_bytes < 7'(FRAME_BYTES)) ? i_payload_bytes : 7'(FRAME_BYTES);
        s = r_item.start_bit[2:0];
        sb = r_item.start_bit[8:3];
        is_ins = (r_item.mode == MODE_INSERT);
        sig_mode = is_ins || (r_item.mode == MODE_EXTRACT);
        if (r_item.motorola_order) begin
            span = 8'(3'd7 - s) + 8'(r_item.bit_count) - 8'd1;
        end else begin
            span = 8'(s) + 8'(r_item.bit_count) - 8'd1;
        end
        kb = span[7:3];
        last = 7'(sb) + 7'(kb);
        bad_count = (r_item.bit_count == 7'd0) || (r_item.bit_count > 7'd64);
        if (sig_mode) begin
            c_err = bad_count || (last >= len);
            // extract fills the accumulator most significant byte first, insert consumes least significant first
            c_inc = r_item.motorola_order ^ is_ins;
            c_addr = c_inc ? sb[AW-1:0] : last[AW-1:0];
            c_k = 4'(kb) + 4'd1;
            c_sh = r_item.motorola_order ? ~span[2:0] : s;
            c_nbits = r_item.bit_count;
            c_sext = r_item.sign_extend && !is_ins;
            c_value = r_item.signal_value;
            c_write = is_ins;
        end else begin
            c_err = (7'(r_item.byte_index) >= len);
            c_inc = 1'b1;
            c_addr = r_item.byte_index[AW-1:0];
            c_k = 4'd1;
            c_sh = 3'd0;
            c_nbits = 7'd8;
            c_sext = 1'b0;
            c_value = 64'(r_item.byte_value);
            c_write = (r_item.mode == MODE_WRITE);
        end
    end

    assign issue = (r_state == S_RUN) && (r_left != 4'd0);

    assign o_ctl.load     = (r_state == S_CHK);
    assign o_ctl.step     = r_rv;
    assign o_ctl.err      = c_err;
    assign o_ctl.zero_res = c_err || c_write;
    assign o_ctl.sext     = c_sext;
    assign o_ctl.sh       = c_sh;
    assign o_ctl.nbits    = c_nbits;
    assign o_value        = c_value;

    assign o_re        = issue;
    assign o_raddr     = r_addr;
    assign o_we        = r_rv && r_write;
    assign o_waddr     = r_waddr;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_FIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv <= 1'b0;
        end else begin
            r_rv <= issue;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= c_err ? S_FIN : S_RUN;
                end
                S_RUN: begin
                    // leave once the last read byte has been merged
                    if (r_left == 4'd0 && r_rv) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (r_state == S_CHK) begin
            r_addr <= c_addr;
            r_left <= c_k;
            r_inc <= c_inc;
            r_write <= c_write;
        end else if (issue) begin
            r_addr <= r_inc ? r_addr + AW'(1) : r_addr - AW'(1);
            r_left <= r_left - 4'd1;
        end
        if (issue) begin
            r_waddr <= r_addr;
        end
    end

endmodule

// ===== hdl/cspu_datapath.sv =====
// Byte-wide shift datapath: insert field/mask shifters, extract accumulator.
module cspu_datapath (
    input  logic                i_clk,
    input  cspu_pkg::t_dp_ctl   i_ctl,
    input  logic [63:0]         i_value,
    input  logic [7:0]          i_rdata,
    output logic [7:0]          o_wdata,
    output cspu_pkg::t_out_item o_result
);
    import cspu_pkg::*;

    logic [71:0] r_f;
    logic [71:0] r_fm;
    logic [71:0] r_acc;
    logic [63:0] r_mask;
    logic [2:0]  r_sh;
    logic        r_sext;
    logic        r_zero;
    logic        r_err;

    logic [63:0] mask_c;
    logic [63:0] aligned;
    logic [63:0] mv;
    logic        sign;

    always_comb begin
        for (int i = 0; i < 64; i++) begin
            mask_c[i] = (7'(i) < i_ctl.nbits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_f <= {8'd0, i_value & mask_c} << i_ctl.sh;
            r_fm <= {8'd0, mask_c} << i_ctl.sh;
            r_acc <= '0;
            r_mask <= mask_c;
            r_sh <= i_ctl.sh;
            r_sext <= i_ctl.sext;
            r_zero <= i_ctl.zero_res;
            r_err <= i_ctl.err;
        end else if (i_ctl.step) begin
            // advance one payload byte
            r_f <= r_f >> 8;
            r_fm <= r_fm >> 8;
            r_acc <= {r_acc[63:0], i_rdata};
        end
    end

    // merge: keep neighbor bits, replace the signal's bits
    assign o_wdata = (i_rdata & ~r_fm[7:0]) | (r_f[7:0] & r_fm[7:0]);

    always_comb begin
        aligned = 64'(r_acc >> r_sh);
        mv = aligned & r_mask;
        sign = |(mv & r_mask & ~(r_mask >> 1));
        if (r_zero) begin
            o_result.result_value = '0;
        end else if (r_sext && sign) begin
            o_result.result_value = mv | ~r_mask;
        end else begin
            o_result.result_value = mv;
        end
        o_result.range_error = r_err;
    end

endmodule

// ===== hdl/can_signal_pack_unpack_top.sv =====
// CAN payload store with byte access and Intel/Motorola signal packing.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one item: write
// byte, read byte, insert signal or extract signal. Output channel
// (o_out_valid / i_out_stall / o_out_item) returns exactly one result per
// item, in order. The APB port holds payload_bytes at address 0.
//
// An item occupies the engine while it walks the k payload bytes that it
// touches: 1 for byte access, up to 9 for a 64-bit signal. The byte
// store has one read and one write port and is walked one byte per cycle,
// which sets how long an item holds the engine. A refused item
// (range_error) skips the walk and goes from the check state to the result.
//
// A finished result waits in the output register while the next item is
// taken; if the receiver still stalls when the following result is done,
// the engine holds it and o_in_stall stays high. Reset clears the control
// state and sets payload_bytes to 8; payload bytes are undefined until
// written.
module can_signal_pack_unpack_top #(
    parameter int FRAME_BYTES = cspu_pkg::FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cspu_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cspu_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cspu_pkg::t_out_item                 o_out_item
);
    import cspu_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    logic [6:0]    r_payload_bytes;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          cfg_hit;
    logic          res_valid;
    logic          res_ready;
    t_dp_ctl       dp_ctl;
    logic [63:0]   dp_value;
    t_out_item     dp_result;
    logic [7:0]    rdata;
    logic [7:0]    wdata;
    logic          re;
    logic          we;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1] == REG_IDX_PAYLOAD_BYTES);
    assign prdata  = cfg_hit ? 32'(r_payload_bytes) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_bytes <= PAYLOAD_BYTES_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_payload_bytes <= pwdata[6:0];
        end
    end

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= dp_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    cspu_ctrl #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_item       (i_in_item),
        .o_in_stall      (o_in_stall),
        .i_payload_bytes (r_payload_bytes),
        .i_res_ready     (res_ready),
        .o_res_valid     (res_valid),
        .o_ctl           (dp_ctl),
        .o_value         (dp_value),
        .o_re            (re),
        .o_raddr         (raddr),
        .o_we            (we),
        .o_waddr         (waddr)
    );

    cspu_datapath u_datapath (
        .i_clk    (i_clk),
        .i_ctl    (dp_ctl),
        .i_value  (dp_value),
        .i_rdata  (rdata),
        .o_wdata  (wdata),
        .o_result (dp_result)
    );

    cspu_store #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
